// File: src/ohm_pkg.sv
// ----------------------------------------------------------------------------
// ohm_pkg
// Shared types and codes for the open-addressed hash map: slot states,
// request and status codes, the controller state and the small control
// structs that pass between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ohm_pkg;

    localparam int CNT_W = 11;

    // Multiplier of the key hash, taken modulo 2^32.
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B9;

    localparam logic [CNT_W-1:0] MAX_FILL_RESET = 11'd768;

    // Request codes carried on the input tuser.
    localparam logic [1:0] OP_GET    = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    // Slot status codes as held in the slot memory.
    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_LIVE  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_START,
        S_PROBE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] live;
    } t_res_info;

endpackage

`default_nettype wire

// File: src/ohm_slot_ram.sv
// ----------------------------------------------------------------------------
// ohm_slot_ram
// Slot memory: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ohm_slot_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 66
) (
    input  wire                     i_clk,
    input  ohm_pkg::t_mem_ctl       i_ctl,
    input  wire [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire [WIDTH-1:0]         i_wr_data,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]        o_rd_data
);

    logic [WIDTH-1:0] r_slots [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_slots[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_slots[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: src/ohm_engine.sv
// ----------------------------------------------------------------------------
// ohm_engine
// Request controller: hashes the key, walks the probe sequence through the
// slot memory one slot per cycle, then writes back the single changed slot, if any,
// and updates the live and used counters.
// ----------------------------------------------------------------------------
`default_nettype none

module ohm_engine #(
    parameter int CAPACITY   = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_start,
    input  wire [1:0]                           i_op,
    input  wire [KEY_BITS-1:0]                  i_key,
    input  wire [VALUE_BITS-1:0]                i_value,
    input  wire [ohm_pkg::CNT_W-1:0]            i_max_fill,
    output logic                                o_idle,
    input  wire                                 i_res_free,
    output logic                                o_res_valid,
    output ohm_pkg::t_res_info                  o_res,
    output logic [VALUE_BITS-1:0]               o_res_value,
    output ohm_pkg::t_mem_ctl                   o_mem_ctl,
    output logic [$clog2(CAPACITY)-1:0]         o_rd_addr,
    output logic [$clog2(CAPACITY)-1:0]         o_wr_addr,
    output logic [2+KEY_BITS+VALUE_BITS-1:0]    o_wr_data,
    input  wire [2+KEY_BITS+VALUE_BITS-1:0]     i_rd_data
);

    localparam int IW = $clog2(CAPACITY);
    localparam int KL = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);

    ohm_pkg::t_state r_state, n_state;

    logic [1:0]               r_op;
    logic [KEY_BITS-1:0]      r_key;
    logic [VALUE_BITS-1:0]    r_value;
    logic [31:0]              r_hash;
    logic [IW-1:0]            r_stride;
    logic [IW-1:0]            r_cur;
    logic [IW-1:0]            r_cnt;
    logic [IW-1:0]            r_clr;
    logic                     r_found;
    logic [IW-1:0]            r_hit_idx;
    logic [VALUE_BITS-1:0]    r_hit_value;
    logic                     r_has_free;
    logic [IW-1:0]            r_free_idx;
    logic                     r_free_tomb;
    logic [ohm_pkg::CNT_W-1:0] r_live, n_live;
    logic [ohm_pkg::CNT_W-1:0] r_used, n_used;

    logic [1:0]            w_slot_status;
    logic [KEY_BITS-1:0]   w_slot_key;
    logic [VALUE_BITS-1:0] w_slot_value;
    logic                  w_live;
    logic                  w_empty;
    logic                  w_match;
    logic                  w_probe_end;
    logic [IW-1:0]         w_next_idx;
    logic [31:0]           w_stride_full;
    logic                  w_finish;

    // Decision of the finishing cycle.
    logic [1:0]    w_status;
    logic          w_write;
    logic [IW-1:0] w_target;
    logic [1:0]    w_new_status;

    assign w_slot_status = i_rd_data[2+KEY_BITS+VALUE_BITS-1 -: 2];
    assign w_slot_key    = i_rd_data[VALUE_BITS +: KEY_BITS];
    assign w_slot_value  = i_rd_data[VALUE_BITS-1:0];
    assign w_live        = (w_slot_status == ohm_pkg::SLOT_LIVE);
    assign w_empty       = (w_slot_status == ohm_pkg::SLOT_EMPTY);
    assign w_match       = w_live && (w_slot_key == r_key);
    assign w_probe_end   = w_match || w_empty || (r_cnt == LAST_IDX);
    assign w_next_idx    = r_cur + r_stride;
    assign w_stride_full = (r_hash >> 3) | 32'd1;
    assign w_finish      = (r_state == ohm_pkg::S_FINISH) && i_res_free;

    always_comb begin
        w_status     = ohm_pkg::STAT_NOT_FOUND;
        w_write      = 1'b0;
        w_target     = r_hit_idx;
        w_new_status = ohm_pkg::SLOT_LIVE;
        n_live       = r_live;
        n_used       = r_used;
        unique case (r_op)
            ohm_pkg::OP_GET: begin
                if (r_found) begin
                    w_status = ohm_pkg::STAT_OK;
                end
            end
            ohm_pkg::OP_SET: begin
                priority if (r_found) begin
                    w_status = ohm_pkg::STAT_OK;
                    w_write  = 1'b1;
                end else if (!r_has_free) begin
                    w_status = ohm_pkg::STAT_FULL;
                end else if (r_free_tomb) begin
                    w_status = ohm_pkg::STAT_OK;
                    w_write  = 1'b1;
                    w_target = r_free_idx;
                    n_live   = r_live + 1'b1;
                end else if (({1'b0, r_used} + 1'b1) > {1'b0, i_max_fill}) begin
                    w_status = ohm_pkg::STAT_FULL;
                end else begin
                    w_status = ohm_pkg::STAT_OK;
                    w_write  = 1'b1;
                    w_target = r_free_idx;
                    n_live   = r_live + 1'b1;
                    n_used   = r_used + 1'b1;
                end
            end
            ohm_pkg::OP_REMOVE: begin
                if (r_found) begin
                    w_status     = ohm_pkg::STAT_OK;
                    w_write      = 1'b1;
                    w_new_status = ohm_pkg::SLOT_TOMB;
                    if (r_live != '0) begin
                        n_live = r_live - 1'b1;
                    end
                end
            end
            default: begin
                w_status = ohm_pkg::STAT_NOT_FOUND;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ohm_pkg::S_CLEAR: begin
                if (r_clr == LAST_IDX) begin
                    n_state = ohm_pkg::S_IDLE;
                end
            end
            ohm_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = ohm_pkg::S_HASH;
                end
            end
            ohm_pkg::S_HASH:  n_state = ohm_pkg::S_START;
            ohm_pkg::S_START: n_state = ohm_pkg::S_PROBE;
            ohm_pkg::S_PROBE: begin
                if (w_probe_end) begin
                    n_state = ohm_pkg::S_FINISH;
                end
            end
            ohm_pkg::S_FINISH: begin
                if (i_res_free) begin
                    n_state = ohm_pkg::S_IDLE;
                end
            end
            default: n_state = ohm_pkg::S_IDLE;
        endcase
    end

    // Outputs: memory port and result.
    always_comb begin
        o_mem_ctl   = '0;
        o_rd_addr   = w_next_idx;
        o_wr_addr   = w_target;
        o_wr_data   = {w_new_status, r_key, r_value};
        o_idle      = 1'b0;
        o_res_valid = 1'b0;
        o_res.status = w_status;
        o_res.live   = n_live;
        o_res_value  = (r_op == ohm_pkg::OP_GET && r_found) ? r_hit_value : '0;
        unique case (r_state)
            ohm_pkg::S_CLEAR: begin
                o_mem_ctl.wr_en = 1'b1;
                o_wr_addr       = r_clr;
                o_wr_data       = {ohm_pkg::SLOT_EMPTY, {(KEY_BITS+VALUE_BITS){1'b0}}};
            end
            ohm_pkg::S_IDLE: begin
                o_idle = 1'b1;
            end
            ohm_pkg::S_START: begin
                o_mem_ctl.rd_en = 1'b1;
                o_rd_addr       = r_hash[IW-1:0];
            end
            ohm_pkg::S_PROBE: begin
                o_mem_ctl.rd_en = !w_probe_end;
            end
            ohm_pkg::S_FINISH: begin
                o_mem_ctl.wr_en = w_write && i_res_free;
                o_res_valid     = i_res_free;
            end
            default: begin
                o_idle = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ohm_pkg::S_CLEAR;
            r_clr   <= '0;
            r_live  <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ohm_pkg::S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_finish) begin
                r_live <= n_live;
                r_used <= n_used;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ohm_pkg::S_IDLE && i_start) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (r_state == ohm_pkg::S_HASH) begin
            r_hash <= 32'(32'(r_key[KL-1:0]) * ohm_pkg::HASH_MULT);
        end
        if (r_state == ohm_pkg::S_START) begin
            r_stride   <= w_stride_full[IW-1:0];
            r_cur      <= r_hash[IW-1:0];
            r_cnt      <= '0;
            r_found    <= 1'b0;
            r_has_free <= 1'b0;
        end
        if (r_state == ohm_pkg::S_PROBE) begin
            if (w_match) begin
                r_found     <= 1'b1;
                r_hit_idx   <= r_cur;
                r_hit_value <= w_slot_value;
            end else if (!w_live && !r_has_free) begin
                // First slot on the path that a new key may take.
                r_has_free  <= 1'b1;
                r_free_idx  <= r_cur;
                r_free_tomb <= !w_empty;
            end
            if (!w_probe_end) begin
                r_cur <= w_next_idx;
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    a_live_within_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= r_used)
        else $error("live count exceeds non-empty slot count");

    a_no_start_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ohm_pkg::S_CLEAR) |-> !o_idle)
        else $error("item taken during the clearing pass");

    a_write_only_clear_or_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_ctl.wr_en |-> (r_state == ohm_pkg::S_CLEAR || w_finish))
        else $error("slot write outside clearing or finishing");

    a_no_read_write_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_ctl.wr_en && o_mem_ctl.rd_en))
        else $error("slot read and write in the same cycle");

    a_result_after_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ohm_pkg::S_PROBE && w_probe_end) |=> (r_state == ohm_pkg::S_FINISH))
        else $error("probe end did not lead to a result");

endmodule

`default_nettype wire

// File: src/open_addressed_hash_map.sv
// ----------------------------------------------------------------------------
// open_addressed_hash_map
// Key-value store with open addressing and double-hash probing over a slot
// memory. Each slot is empty, live or a tombstone; requests get, set or
// remove one key.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+-------------------------------
//   s        | in  | i_s_tvalid/o_s_tready  | tdata: key, value; tuser: op
//   m        | out | o_m_tvalid/i_m_tready  | tdata: read_value, live_entries;
//            |     |                        | tuser: status
//   cfg      | in  | i_cfg_wr_en            | i_cfg_wr_data: max_fill
//
// An item runs through accept, hash multiply, first read, one slot read per
// cycle on the single slot memory read port for each of the P slots probed
// (1 up to CAPACITY), then write-back and result.
// After reset a clearing pass marks every slot empty, and no item is accepted
// during it.
// A finished result waits in the output register; the next item is accepted
// meanwhile and its result is held back until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module open_addressed_hash_map #(
    parameter int CAPACITY   = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire                                            i_clk,
    input  wire                                            i_rst_n,
    input  wire                                            i_s_tvalid,
    output logic                                           o_s_tready,
    // key, value from the lowest bit up, zero filled to whole bytes
    input  wire [((KEY_BITS+VALUE_BITS+7)/8)*8-1:0]        i_s_tdata,
    // op
    input  wire [1:0]                                      i_s_tuser,
    output logic                                           o_m_tvalid,
    input  wire                                            i_m_tready,
    // read_value, live_entries from the lowest bit up, zero filled to whole bytes
    output logic [((VALUE_BITS+ohm_pkg::CNT_W+7)/8)*8-1:0] o_m_tdata,
    // status
    output logic [1:0]                                     o_m_tuser,
    input  wire                                            i_cfg_wr_en,
    input  wire [ohm_pkg::CNT_W-1:0]                       i_cfg_wr_data
);

    localparam int IW    = $clog2(CAPACITY);
    localparam int SW    = 2 + KEY_BITS + VALUE_BITS;
    localparam int OUT_W = ((VALUE_BITS + ohm_pkg::CNT_W + 7) / 8) * 8;

    logic [ohm_pkg::CNT_W-1:0] r_max_fill;

    logic                      r_m_valid;
    logic [1:0]                r_m_status;
    logic [VALUE_BITS-1:0]     r_m_value;
    logic [ohm_pkg::CNT_W-1:0] r_m_live;

    logic                  w_idle;
    logic                  w_res_free;
    logic                  w_res_valid;
    ohm_pkg::t_res_info    w_res;
    logic [VALUE_BITS-1:0] w_res_value;
    ohm_pkg::t_mem_ctl     w_mem_ctl;
    logic [IW-1:0]         w_rd_addr;
    logic [IW-1:0]         w_wr_addr;
    logic [SW-1:0]         w_wr_data;
    logic [SW-1:0]         w_rd_data;

    assign o_s_tready = w_idle;
    assign w_res_free = !r_m_valid || i_m_tready;

    ohm_engine #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_s_tvalid && w_idle),
        .i_op        (i_s_tuser),
        .i_key       (i_s_tdata[KEY_BITS-1:0]),
        .i_value     (i_s_tdata[KEY_BITS +: VALUE_BITS]),
        .i_max_fill  (r_max_fill),
        .o_idle      (w_idle),
        .i_res_free  (w_res_free),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_res_value (w_res_value),
        .o_mem_ctl   (w_mem_ctl),
        .o_rd_addr   (w_rd_addr),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .i_rd_data   (w_rd_data)
    );

    ohm_slot_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (SW)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_ctl     (w_mem_ctl),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fill <= ohm_pkg::MAX_FILL_RESET;
            r_m_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_fill <= i_cfg_wr_data;
            end
            if (w_res_valid) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_m_status <= w_res.status;
            r_m_value  <= w_res_value;
            r_m_live   <= w_res.live;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OUT_W'({r_m_live, r_m_value});
    assign o_m_tuser  = r_m_status;

endmodule

`default_nettype wire
